// ===== hdl/spd_pkg.sv =====
package spd_pkg;

    // field widths
    localparam int PULSE_W      = 16;
    localparam int ELAPSED_W    = 8;
    localparam int PERIOD_W     = 16;
    localparam int MM_W         = 16;
    localparam int PPT_W        = 8;
    localparam int SPEED_W      = 16;
    localparam int STEP_W       = 32;
    localparam int ODO_W        = 32;
    localparam int PSUM_W       = 24;
    localparam int TSUM_W       = 17;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // shared divider
    localparam int PROD_W       = PSUM_W + MM_W;          // 40
    localparam int SCALED_W     = PROD_W + 6;             // full step times 36
    localparam int DIVIDEND_W   = 48;
    localparam int DIVISOR_W    = TSUM_W + 4;             // window time times ten
    localparam int ITER_W       = 6;
    localparam logic [ITER_W-1:0] ITERS_PPT  = ITER_W'(PROD_W);
    localparam logic [ITER_W-1:0] ITERS_TIME = ITER_W'(SCALED_W);

    localparam int SPEED_NUM    = 36;
    localparam int SPEED_DEN    = 10;

    // register reset values
    localparam logic [PERIOD_W-1:0] UPDATE_PERIOD_RST = 16'd500;
    localparam logic [MM_W-1:0]     MM_PER_TURN_RST   = 16'd2000;
    localparam logic [PPT_W-1:0]    PPT_RST           = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPDATE_PERIOD   = 2'd0,
        CFG_MM_PER_TURN     = 2'd1,
        CFG_PULSES_PER_TURN = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [PULSE_W-1:0]   pulse_delta;
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic                 no_pulse_timeout;
    } sample_t;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_kmh;
        logic [STEP_W-1:0]  distance_step_mm;
        logic [ODO_W-1:0]   odometer_mm;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_write_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] update_period_ms;
        logic [MM_W-1:0]     mm_per_turn;
        logic [PPT_W-1:0]    pulses_per_turn;
    } cfg_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;   // left aligned
        logic [DIVISOR_W-1:0]  divisor;
        logic [ITER_W-1:0]     iters;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== hdl/spd_chan_if.sv =====
interface spd_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/spd_cfg.sv =====
module spd_cfg #(
    parameter logic [spd_pkg::PERIOD_W-1:0] RST_UPDATE_PERIOD = spd_pkg::UPDATE_PERIOD_RST,
    parameter logic [spd_pkg::MM_W-1:0]     RST_MM_PER_TURN   = spd_pkg::MM_PER_TURN_RST,
    parameter logic [spd_pkg::PPT_W-1:0]    RST_PPT           = spd_pkg::PPT_RST
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  spd_pkg::cfg_write_t wr,
    output spd_pkg::cfg_t       cfg
);

    spd_pkg::cfg_t cfg_reg;
    spd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (spd_pkg::cfg_index_t'(wr.index))
                spd_pkg::CFG_UPDATE_PERIOD:
                    cfg_next.update_period_ms = wr.value[spd_pkg::PERIOD_W-1:0];
                spd_pkg::CFG_MM_PER_TURN:
                    cfg_next.mm_per_turn = wr.value[spd_pkg::MM_W-1:0];
                spd_pkg::CFG_PULSES_PER_TURN:
                    cfg_next.pulses_per_turn = wr.value[spd_pkg::PPT_W-1:0];
                default:
                    cfg_next = cfg_reg;   // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.update_period_ms <= RST_UPDATE_PERIOD;
            cfg_reg.mm_per_turn      <= RST_MM_PER_TURN;
            cfg_reg.pulses_per_turn  <= RST_PPT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/spd_divider.sv =====
module spd_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  spd_pkg::div_req_t req,
    output spd_pkg::div_rsp_t rsp
);

    localparam int DW = spd_pkg::DIVIDEND_W;
    localparam int VW = spd_pkg::DIVISOR_W;

    logic [DW-1:0]             work_reg, work_next;
    logic [VW-1:0]             rem_reg, rem_next;
    logic [VW-1:0]             dvsr_reg, dvsr_next;
    logic [spd_pkg::ITER_W-1:0] cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;

    logic [VW:0] trial;
    logic [VW:0] diff;
    logic        qbit;

    // one restoring step: bring down the next dividend bit
    assign trial = {rem_reg, work_reg[DW-1]};
    assign diff  = trial - {1'b0, dvsr_reg};
    assign qbit  = (trial >= {1'b0, dvsr_reg});

    always_comb
    begin
        work_next = work_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            work_next = req.dividend;
            rem_next  = '0;
            dvsr_next = req.divisor;
            cnt_next  = req.iters;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            work_next = {work_reg[DW-2:0], qbit};
            rem_next  = qbit ? diff[VW-1:0] : trial[VW-1:0];
            cnt_next  = cnt_reg - spd_pkg::ITER_W'(1);
            if (cnt_reg == spd_pkg::ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    // after n steps the low n bits hold the quotient, the rest is zero
    assign rsp.done     = done_reg;
    assign rsp.quotient = work_reg;

endmodule

// ===== hdl/spd_core.sv =====
module spd_core (
    input  logic             clk,
    input  logic             rst_n,
    input  spd_pkg::cfg_t    cfg,
    input  logic             sample_valid,
    input  spd_pkg::sample_t sample_data,
    output logic             sample_ready,
    output logic             result_valid,
    output spd_pkg::result_t result_data,
    input  logic             result_ready
);

    localparam int PSW = spd_pkg::PSUM_W;
    localparam int TSW = spd_pkg::TSUM_W;
    localparam int PW  = spd_pkg::PROD_W;
    localparam int SW  = spd_pkg::SCALED_W;
    localparam int DW  = spd_pkg::DIVIDEND_W;
    localparam int VW  = spd_pkg::DIVISOR_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MUL    = 5'b00010,
        ST_PPT    = 5'b00100,
        ST_TIME   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [PSW-1:0]             psum_reg, psum_next;
    logic [TSW-1:0]             tsum_reg, tsum_next;
    logic [PSW-1:0]             win_pulse_reg, win_pulse_next;
    logic [TSW-1:0]             win_time_reg, win_time_next;
    logic                       win_tmo_reg, win_tmo_next;
    logic [spd_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [spd_pkg::SPEED_W-1:0] speed_reg, speed_next;
    logic [spd_pkg::ODO_W-1:0]   odo_reg, odo_next;
    logic                       res_valid_reg, res_valid_next;
    spd_pkg::result_t           res_reg, res_next;

    spd_pkg::div_req_t div_req;
    spd_pkg::div_rsp_t div_rsp;

    logic [PSW:0]   psum_add;
    logic [TSW:0]   tsum_add;
    logic [PSW-1:0] psum_sat;
    logic [TSW-1:0] tsum_sat;
    logic           accept;
    logic           close;
    logic           out_free;
    logic [PW-1:0]  product;
    logic [PW-1:0]  full_step;
    logic [SW-1:0]  scaled;
    logic [VW-1:0]  ppt_div;
    logic [VW-1:0]  time_div;
    logic [spd_pkg::ODO_W-1:0] odo_sum;

    spd_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // saturating window sums, item included before the close test
    assign psum_add = {1'b0, psum_reg} + (PSW+1)'(sample_data.pulse_delta);
    assign tsum_add = {1'b0, tsum_reg} + (TSW+1)'(sample_data.elapsed_ms);
    assign psum_sat = psum_add[PSW] ? '1 : psum_add[PSW-1:0];
    assign tsum_sat = tsum_add[TSW] ? '1 : tsum_add[TSW-1:0];
    assign close    = (tsum_sat >= TSW'(cfg.update_period_ms)) || sample_data.no_pulse_timeout;

    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign out_free     = !res_valid_reg || result_ready;

    assign product   = PW'(win_pulse_reg) * PW'(cfg.mm_per_turn);
    assign ppt_div   = (cfg.pulses_per_turn == '0) ? VW'(1) : VW'(cfg.pulses_per_turn);
    assign full_step = div_rsp.quotient[PW-1:0];
    assign scaled    = SW'(full_step) * SW'(spd_pkg::SPEED_NUM);
    // step*36/10/t equals step*36/(10*t) in whole numbers
    assign time_div  = VW'(win_time_reg) * VW'(spd_pkg::SPEED_DEN);
    assign odo_sum   = odo_reg + step_reg;

    always_comb
    begin
        state_next     = state_reg;
        psum_next      = psum_reg;
        tsum_next      = tsum_reg;
        win_pulse_next = win_pulse_reg;
        win_time_next  = win_time_reg;
        win_tmo_next   = win_tmo_reg;
        step_next      = step_reg;
        speed_next     = speed_reg;
        odo_next       = odo_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !result_ready;
        div_req        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (close)
                    begin
                        win_pulse_next = psum_sat;
                        win_time_next  = tsum_sat;
                        win_tmo_next   = sample_data.no_pulse_timeout;
                        psum_next      = '0;
                        tsum_next      = '0;
                        state_next     = ST_MUL;
                    end
                    else
                    begin
                        psum_next = psum_sat;
                        tsum_next = tsum_sat;
                    end
                end
            end
            ST_MUL:
            begin
                // product straight into the divider load
                div_req.start    = 1'b1;
                div_req.dividend = {product, (DW-PW)'(0)};
                div_req.divisor  = ppt_div;
                div_req.iters    = spd_pkg::ITERS_PPT;
                state_next       = ST_PPT;
            end
            ST_PPT:
            begin
                if (div_rsp.done)
                begin
                    step_next = (|full_step[PW-1:spd_pkg::STEP_W]) ? '1
                              : full_step[spd_pkg::STEP_W-1:0];
                    if (win_tmo_reg || (win_time_reg == '0))
                    begin
                        speed_next = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {scaled, (DW-SW)'(0)};
                        div_req.divisor  = time_div;
                        div_req.iters    = spd_pkg::ITERS_TIME;
                        state_next       = ST_TIME;
                    end
                end
            end
            ST_TIME:
            begin
                if (div_rsp.done)
                begin
                    speed_next = (|div_rsp.quotient[SW-1:spd_pkg::SPEED_W]) ? '1
                               : div_rsp.quotient[spd_pkg::SPEED_W-1:0];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    odo_next                  = odo_sum;
                    res_next.speed_kmh        = speed_reg;
                    res_next.distance_step_mm = step_reg;
                    res_next.odometer_mm      = odo_sum;
                    res_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            psum_reg      <= '0;
            tsum_reg      <= '0;
            odo_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            psum_reg      <= psum_next;
            tsum_reg      <= tsum_next;
            odo_reg       <= odo_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_pulse_reg <= win_pulse_next;
        win_time_reg  <= win_time_next;
        win_tmo_reg   <= win_tmo_next;
        step_reg      <= step_next;
        speed_reg     <= speed_next;
        res_reg       <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result_data  = res_reg;

endmodule

// ===== hdl/wheel_speed_and_odometer.sv =====
// channel  | dir | payload                                          | taken when
// ---------+-----+--------------------------------------------------+--------------------
// sample   | in  | pulse_delta, elapsed_ms, no_pulse_timeout        | valid && ready
// result   | out | speed_kmh, distance_step_mm, odometer_mm         | valid && ready
// cfg      | in  | index, value (update period, mm/turn, pulses/turn)| valid && ready
//
// an item that leaves its window open keeps the block idle; a closing item holds
// the input through a multiply, the pulses-per-turn divide (40-bit quotient) and
// step*36 over ten times the window time (46-bit quotient), all on the shared
// 1-bit/cycle divider; on timeout or zero window time the second divide is skipped
// after reset the block takes items at once; cfg is always ready
// a pending result waits in the output register; only the next closing item stalls on it

module wheel_speed_and_odometer #(
    parameter logic [spd_pkg::PERIOD_W-1:0] RST_UPDATE_PERIOD = spd_pkg::UPDATE_PERIOD_RST,
    parameter logic [spd_pkg::MM_W-1:0]     RST_MM_PER_TURN   = spd_pkg::MM_PER_TURN_RST,
    parameter logic [spd_pkg::PPT_W-1:0]    RST_PPT           = spd_pkg::PPT_RST
) (
    input logic        clk,
    input logic        rst_n,
    spd_chan_if.sink   sample,
    spd_chan_if.source result,
    spd_chan_if.sink   cfg
);

    spd_pkg::cfg_t cfg_regs;

    // register file, written any cycle
    assign cfg.ready = 1'b1;

    spd_cfg #(
        .RST_UPDATE_PERIOD (RST_UPDATE_PERIOD),
        .RST_MM_PER_TURN   (RST_MM_PER_TURN),
        .RST_PPT           (RST_PPT)
    ) u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg.valid),
        .wr    (cfg.data),
        .cfg   (cfg_regs)
    );

    // accumulate, then multiply and up to two divides on one shared divider
    spd_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_regs),
        .sample_valid (sample.valid),
        .sample_data  (sample.data),
        .sample_ready (sample.ready),
        .result_valid (result.valid),
        .result_data  (result.data),
        .result_ready (result.ready)
    );

endmodule

// ===== test/tb_wheel_speed_and_odometer.sv =====
`timescale 1ns / 1ps

class odo_tracker;
    spd_pkg::result_t due_readings[$];
    int unsigned      errors;

    bit [spd_pkg::PERIOD_W-1:0] period_ms;
    bit [spd_pkg::MM_W-1:0]     mm_turn;
    bit [spd_pkg::PPT_W-1:0]    ppt;

    bit [spd_pkg::PSUM_W-1:0]   pulse_sum;
    bit [spd_pkg::TSUM_W-1:0]   time_sum;
    bit [spd_pkg::ODO_W-1:0]    odo;

    function new();
        period_ms = spd_pkg::UPDATE_PERIOD_RST;
        mm_turn   = spd_pkg::MM_PER_TURN_RST;
        ppt       = spd_pkg::PPT_RST;
        pulse_sum = '0;
        time_sum  = '0;
        odo       = '0;
        errors    = 0;
    endfunction

    function void set_reg(logic [spd_pkg::CFG_IDX_W-1:0] idx,
                          logic [spd_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            spd_pkg::CFG_UPDATE_PERIOD:   period_ms = val;
            spd_pkg::CFG_MM_PER_TURN:     mm_turn   = val;
            spd_pkg::CFG_PULSES_PER_TURN: ppt       = val[spd_pkg::PPT_W-1:0];
            default: ;
        endcase
    endfunction

    // fold one accepted sample into the window, queue a reading when it closes
    function void take_sample(spd_pkg::sample_t s);
        bit [spd_pkg::PSUM_W:0] psum_wide;
        bit [spd_pkg::TSUM_W:0] tsum_wide;
        bit [63:0]              divisor;
        bit [63:0]              full_step;
        bit [63:0]              speed_wide;
        spd_pkg::result_t       r;
        psum_wide = (spd_pkg::PSUM_W+1)'(pulse_sum) + (spd_pkg::PSUM_W+1)'(s.pulse_delta);
        pulse_sum = psum_wide[spd_pkg::PSUM_W] ? '1 : psum_wide[spd_pkg::PSUM_W-1:0];
        tsum_wide = (spd_pkg::TSUM_W+1)'(time_sum) + (spd_pkg::TSUM_W+1)'(s.elapsed_ms);
        time_sum  = tsum_wide[spd_pkg::TSUM_W] ? '1 : tsum_wide[spd_pkg::TSUM_W-1:0];
        if (!(time_sum >= period_ms || s.no_pulse_timeout))
            return;
        divisor   = (ppt == 0) ? 64'd1 : 64'(ppt);
        full_step = (64'(pulse_sum) * 64'(mm_turn)) / divisor;
        r.distance_step_mm = (full_step > 64'hFFFF_FFFF) ? '1 : full_step[31:0];
        if (s.no_pulse_timeout || time_sum == 0)
            r.speed_kmh = '0;
        else
        begin
            speed_wide = full_step * 64'(spd_pkg::SPEED_NUM) / 64'(spd_pkg::SPEED_DEN)
                         / 64'(time_sum);
            r.speed_kmh = (speed_wide > 64'hFFFF) ? '1 : speed_wide[15:0];
        end
        odo = odo + r.distance_step_mm;
        r.odometer_mm = odo;
        due_readings.push_back(r);
        pulse_sum = '0;
        time_sum  = '0;
    endfunction

    function void check_reading(spd_pkg::result_t got);
        spd_pkg::result_t want;
        if (due_readings.size() == 0)
        begin
            $error("unexpected result: speed_kmh %0d distance_step_mm %0d odometer_mm %0d",
                   got.speed_kmh, got.distance_step_mm, got.odometer_mm);
            errors++;
            return;
        end
        want = due_readings.pop_front();
        if (got.speed_kmh !== want.speed_kmh)
        begin
            $error("speed_kmh: expected %0d, actual %0d", want.speed_kmh, got.speed_kmh);
            errors++;
        end
        if (got.distance_step_mm !== want.distance_step_mm)
        begin
            $error("distance_step_mm: expected %0d, actual %0d",
                   want.distance_step_mm, got.distance_step_mm);
            errors++;
        end
        if (got.odometer_mm !== want.odometer_mm)
        begin
            $error("odometer_mm: expected %0d, actual %0d", want.odometer_mm, got.odometer_mm);
            errors++;
        end
    endfunction
endclass

module tb_wheel_speed_and_odometer;

    // spare register index, writes to it must be dropped
    localparam logic [spd_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
    // give a closing item room to finish before a cfg write
    localparam int SETTLE_CYCLES = 200;
    // cycles with no handshake on any channel before the run is declared hung
    localparam int HANG_LIMIT    = 4000;

    logic clk;
    logic rst_n;
    bit   quiet;          // no idling on either side once set
    int   idle_cycles = 0;

    odo_tracker tracker = new();

    spd_chan_if #(.payload_t(spd_pkg::sample_t))    sample_ch ();
    spd_chan_if #(.payload_t(spd_pkg::result_t))    result_ch ();
    spd_chan_if #(.payload_t(spd_pkg::cfg_write_t)) cfg_ch ();

    wheel_speed_and_odometer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // build one sample item
    function automatic spd_pkg::sample_t mk(input logic [spd_pkg::PULSE_W-1:0] pd,
                                            input logic [spd_pkg::ELAPSED_W-1:0] el,
                                            input logic to);
        spd_pkg::sample_t s;
        s.pulse_delta      = pd;
        s.elapsed_ms       = el;
        s.no_pulse_timeout = to;
        return s;
    endfunction

    // random sample: edges of both fields often, otherwise small or full-range values
    function automatic spd_pkg::sample_t random_sample();
        int unsigned      pick;
        spd_pkg::sample_t s;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            s.pulse_delta = '0;
        else if (pick == 1)
            s.pulse_delta = '1;
        else if (pick < 6)
            s.pulse_delta = spd_pkg::PULSE_W'($urandom_range(0, 200));
        else
            s.pulse_delta = spd_pkg::PULSE_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            s.elapsed_ms = '0;
        else if (pick == 1)
            s.elapsed_ms = '1;
        else
            s.elapsed_ms = spd_pkg::ELAPSED_W'($urandom_range(0, 255));
        s.no_pulse_timeout = ($urandom_range(0, 15) == 0);
        return s;
    endfunction

    // offer one sample, optionally after a gap; valid stays high after the handshake
    task automatic send_sample(input spd_pkg::sample_t s);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= s;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        tracker.take_sample(s);
    endtask

    task automatic run_random(input int n);
        repeat (n) send_sample(random_sample());
    endtask

    // drop the sample stream, drain every reading, then let the block settle
    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        while (tracker.due_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // cfg valid stays high after the handshake so back-to-back writes need no toggle
    task automatic write_reg(input logic [spd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [spd_pkg::CFG_DATA_W-1:0] val);
        spd_pkg::cfg_write_t w;
        w.index = idx;
        w.value = val;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= w;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        tracker.set_reg(idx, val);
    endtask

    task automatic program_regs(input logic [spd_pkg::PERIOD_W-1:0] period,
                                input logic [spd_pkg::MM_W-1:0] mm,
                                input logic [spd_pkg::PPT_W-1:0] ppt);
        wait_idle();
        write_reg(spd_pkg::CFG_UPDATE_PERIOD, period);
        write_reg(spd_pkg::CFG_MM_PER_TURN, mm);
        write_reg(spd_pkg::CFG_PULSES_PER_TURN, spd_pkg::CFG_DATA_W'(ppt));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic program_random_regs();
        logic [spd_pkg::PERIOD_W-1:0] period;
        // long periods make readings rare, so keep most windows short
        if ($urandom_range(0, 3) == 0)
            period = spd_pkg::PERIOD_W'($urandom);
        else
            period = spd_pkg::PERIOD_W'($urandom_range(1, 1200));
        program_regs(period, spd_pkg::MM_W'($urandom),
                     spd_pkg::PPT_W'($urandom_range(0, 255)));
    endtask

    // result side: ready drops in random bursts until the quiet part
    initial
    begin
        int stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (quiet)
                result_ch.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // every reading the block hands over goes to the checker
    always @(posedge clk)
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            tracker.check_reading(result_ch.data);

    // hang detection on all three channels
    always @(posedge clk)
    begin
        if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        quiet           = 1'b0;
        rst_n           <= 1'b0;
        sample_ch.valid <= 1'b0;
        sample_ch.data  <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.data     <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: 500 ms window, 2000 mm per turn, one pulse per turn
        send_sample(mk('0, '0, 1'b0));              // nothing, window stays open
        send_sample(mk('0, '0, 1'b1));              // timeout on an empty window
        send_sample(mk('1, '1, 1'b0));
        send_sample(mk('1, '1, 1'b0));              // 510 ms, counted before the test
        send_sample(mk(16'd1, 8'd250, 1'b0));
        send_sample(mk(16'd0, 8'd250, 1'b0));       // exactly on the period
        send_sample(mk(16'd100, 8'd254, 1'b0));
        send_sample(mk(16'd100, 8'd10, 1'b1));      // timeout, distance still counted
        send_sample(mk('1, '1, 1'b1));

        // zero period closes every item, zero pulses per turn acts as one
        program_regs('0, '1, '0);
        send_sample(mk('0, '0, 1'b0));              // zero window time
        send_sample(mk('1, '0, 1'b0));
        send_sample(mk('1, '1, 1'b0));
        send_sample(mk(16'd1, 8'd1, 1'b0));

        // one ms window, full step: speed clips, odometer wraps
        program_regs(16'd1, '1, 8'd1);
        send_sample(mk('1, 8'd1, 1'b0));
        send_sample(mk('1, 8'd1, 1'b0));
        send_sample(mk('0, 8'd1, 1'b0));
        send_sample(mk('1, '0, 1'b0));              // below the period, left open
        send_sample(mk(16'd3, 8'd2, 1'b0));

        // no distance per turn, many pulses per turn
        program_regs('1, '0, '1);
        send_sample(mk('1, '1, 1'b1));
        send_sample(mk(16'd7, 8'd3, 1'b0));
        send_sample(mk(16'd9, 8'd1, 1'b1));

        // random traffic at the reset settings
        program_regs(spd_pkg::UPDATE_PERIOD_RST, spd_pkg::MM_PER_TURN_RST, spd_pkg::PPT_RST);
        run_random(60);

        program_regs(16'd1, '1, 8'd1);
        run_random(80);

        program_regs('0, spd_pkg::MM_W'($urandom), '0);
        run_random(60);

        // long window: pulse sum clips at its top, then the step clips too
        program_regs('1, '1, 8'd1);
        repeat (270)
            send_sample(mk('1, spd_pkg::ELAPSED_W'($urandom_range(0, 200)), 1'b0));
        send_sample(mk('1, spd_pkg::ELAPSED_W'($urandom_range(0, 255)), 1'b1));

        program_regs(16'd300, 16'd1, '1);
        run_random(40);

        // a write to the spare index must leave every setting alone
        wait_idle();
        write_reg(CFG_SPARE_IDX, spd_pkg::CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;
        run_random(30);

        repeat (6)
        begin
            program_random_regs();
            run_random(50);
        end

        // last stretch with both sides streaming
        wait_idle();
        quiet = 1'b1;
        program_random_regs();
        run_random(100);

        sample_ch.valid <= 1'b0;
        while (tracker.due_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
